[rtl/sdp_pkg.sv]
// Package for the span depot: sizes, op and outcome codes, queue entry type.
// No dependencies.
package sdp_pkg;

    localparam int DEPOT_SLOTS  = 64;
    localparam int CLASS_COUNT  = 32;
    localparam int SPAN_SHIFT   = 16;
    localparam int ADDRESS_BITS = 48;
    localparam int IDX_W        = $clog2(DEPOT_SLOTS);
    localparam int CNT_W        = $clog2(DEPOT_SLOTS + 1);
    localparam int CLS_W        = 5;

    typedef enum logic [2:0] {
        OP_RESERVE = 3'd0,
        OP_RELEASE = 3'd1,
        OP_PUT_RES = 3'd2,
        OP_PUT_OWN = 3'd3,
        OP_TAKE    = 3'd4,
        OP_CLEAR   = 3'd5,
        OP_NONE6   = 3'd6,
        OP_NONE7   = 3'd7
    } op_t;

    localparam logic [1:0] OUT_REFUSED = 2'd0;
    localparam logic [1:0] OUT_DONE    = 2'd1;
    localparam logic [1:0] OUT_DUP     = 2'd2;

    typedef struct packed {
        op_t                       op;
        logic [ADDRESS_BITS-1:0]   span;
        logic [7:0]                cls;
        logic [7:0]                amount;
        logic                      span_ok;
    } cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_CHECK,
        ST_MOVE,
        ST_WRITE,
        ST_OUT
    } state_t;

endpackage

[rtl/sdp_front.sv]
// Front end: accepts input beats, validates put spans, pushes commands to queue.
// Depends on sdp_pkg.
module sdp_front
    import sdp_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic [2:0]              op,
    input  logic [47:0]             span_address,
    input  logic [7:0]              size_class,
    input  logic [7:0]              amount,
    input  logic                    span_discarded,
    input  logic [47:0]             arena_base,
    input  logic [47:0]             arena_bytes,
    output logic                    q_valid,
    output cmd_t                    q_cmd,
    input  logic                    q_pop
);
    localparam int QD = 2;

    cmd_t         q_reg [QD];
    logic         wp_reg, rp_reg;
    logic [1:0]   n_reg;
    logic [47:0]  off;
    logic         ok;
    cmd_t         c;
    logic         push;

    always_comb
    begin
        off = span_address - arena_base;
        ok  = (span_address != '0) && (size_class < 8'(CLASS_COUNT))
            && (span_address >= arena_base) && (off < arena_bytes)
            && (off[SPAN_SHIFT-1:0] == '0) && span_discarded;
        c.op      = op_t'(op);
        c.span    = span_address;
        c.cls     = size_class;
        c.amount  = amount;
        c.span_ok = ok;
    end

    assign in_stall = (n_reg == 2'(QD));
    assign push     = in_valid && !in_stall;
    assign q_valid  = (n_reg != 2'd0);
    assign q_cmd    = q_reg[rp_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wp_reg] <= c;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= 1'b0;
            rp_reg <= 1'b0;
            n_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wp_reg <= ~wp_reg;
            end
            if (q_pop)
            begin
                rp_reg <= ~rp_reg;
            end
            n_reg <= n_reg + 2'(push) - 2'(q_pop);
        end
    end
endmodule

[rtl/sdp_back.sv]
// Back end: executes commands against the span/class memory, scans serially.
// Depends on sdp_pkg.
module sdp_back
    import sdp_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          q_valid,
    input  cmd_t          q_cmd,
    output logic          q_pop,
    output logic          out_valid,
    input  logic          out_stall,
    output logic [1:0]    outcome,
    output logic [6:0]    granted,
    output logic [47:0]   taken_span,
    output logic [4:0]    taken_class,
    output logic [6:0]    entry_count,
    output logic [6:0]    peak_count,
    output logic [6:0]    free_slots
);
    logic [47:0]      span_mem [DEPOT_SLOTS];
    logic [CLS_W-1:0] cls_mem  [DEPOT_SLOTS];

    state_t           st_reg, st_next;
    cmd_t             cmd_reg;
    logic [CNT_W-1:0] filled_reg, peak_reg, held_reg;
    logic             rdy_reg;
    logic [CNT_W-1:0] i_reg;
    logic [47:0]      rd_span_reg;
    logic [CLS_W-1:0] rd_cls_reg;
    logic             hit_reg;
    logic [IDX_W-1:0] hit_idx_reg;
    logic [47:0]      tspan_reg;
    logic [CLS_W-1:0] tcls_reg;
    logic [1:0]       oc_reg;
    logic [6:0]       gr_reg;
    logic             ov_reg;

    logic [CNT_W-1:0] freec;
    logic [CNT_W:0]   used;
    logic             is_put, is_take, scan_done;
    logic [IDX_W-1:0] rd_idx;

    always_comb
    begin
        used  = {1'b0, filled_reg} + {1'b0, held_reg};
        freec = (used >= (CNT_W+1)'(DEPOT_SLOTS)) ? '0
              : CNT_W'((CNT_W+1)'(DEPOT_SLOTS) - used);
    end

    assign is_put  = (cmd_reg.op == OP_PUT_RES) || (cmd_reg.op == OP_PUT_OWN);
    assign is_take = (cmd_reg.op == OP_TAKE);
    // put scans up from 0, take scans down from filled-1
    assign scan_done = is_put ? (i_reg >= filled_reg) : (i_reg == '0);
    assign rd_idx = is_put ? i_reg[IDX_W-1:0] : IDX_W'(i_reg - 1'b1);

    always_comb
    begin
        st_next = st_reg;
        unique case (st_reg)
            ST_IDLE:  if (q_valid) st_next = ST_READ;
            ST_READ:  if (!rdy_reg || !(is_put || is_take)) st_next = ST_OUT;
                      else if (is_put && (!cmd_reg.span_ok ||
                               (cmd_reg.op == OP_PUT_RES && held_reg == '0) ||
                               (cmd_reg.op == OP_PUT_OWN && freec == '0)))
                          st_next = ST_OUT;
                      else if (is_take && cmd_reg.cls >= 8'(CLASS_COUNT))
                          st_next = ST_OUT;
                      else if (scan_done) st_next = is_put ? ST_WRITE : ST_OUT;
                      else st_next = ST_CHECK;
            ST_CHECK: if (is_put && rd_span_reg == cmd_reg.span) st_next = ST_OUT;
                      else if (is_take && rd_cls_reg == cmd_reg.cls[CLS_W-1:0])
                          st_next = ST_MOVE;
                      else st_next = ST_READ;
            ST_MOVE:  st_next = ST_WRITE;
            ST_WRITE: st_next = ST_OUT;
            ST_OUT:   if (!ov_reg || !out_stall) st_next = ST_IDLE;
            default:  st_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        q_pop = (st_reg == ST_IDLE) && q_valid;
    end

    always_ff @(posedge clk)
    begin
        if (st_reg == ST_READ)
        begin
            rd_span_reg <= span_mem[rd_idx];
            rd_cls_reg  <= cls_mem[rd_idx];
        end
        if (st_reg == ST_MOVE)
        begin
            rd_span_reg <= span_mem[IDX_W'(filled_reg - 1'b1)];
            rd_cls_reg  <= cls_mem[IDX_W'(filled_reg - 1'b1)];
        end
        if (st_reg == ST_WRITE)
        begin
            if (is_put)
            begin
                span_mem[filled_reg[IDX_W-1:0]] <= cmd_reg.span;
                cls_mem[filled_reg[IDX_W-1:0]]  <= cmd_reg.cls[CLS_W-1:0];
            end
            else
            begin
                span_mem[hit_idx_reg] <= rd_span_reg;
                cls_mem[hit_idx_reg]  <= rd_cls_reg;
            end
        end
        if (q_pop)
        begin
            cmd_reg <= q_cmd;
        end
        if (st_reg == ST_CHECK && is_take)
        begin
            tspan_reg   <= rd_span_reg;
            tcls_reg    <= rd_cls_reg;
            hit_idx_reg <= IDX_W'(i_reg - 1'b1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg     <= ST_IDLE;
            filled_reg <= '0;
            peak_reg   <= '0;
            held_reg   <= '0;
            rdy_reg    <= 1'b0;
            i_reg      <= '0;
            hit_reg    <= 1'b0;
            oc_reg     <= OUT_REFUSED;
            gr_reg     <= '0;
            ov_reg     <= 1'b0;
        end
        else
        begin
            st_reg <= st_next;
            if (st_reg == ST_OUT && (!ov_reg || !out_stall))
            begin
                ov_reg <= 1'b1;
            end
            else if (ov_reg && !out_stall)
            begin
                ov_reg <= 1'b0;
            end
            unique case (st_reg)
                ST_IDLE:
                begin
                    if (q_valid)
                    begin
                        i_reg   <= (q_cmd.op == OP_TAKE) ? filled_reg : '0;
                        hit_reg <= 1'b0;
                        oc_reg  <= OUT_REFUSED;
                        gr_reg  <= '0;
                    end
                end
                ST_READ:
                begin
                    if (st_next == ST_OUT && rdy_reg)
                    begin
                        unique case (cmd_reg.op)
                            OP_RESERVE:
                            begin
                                logic [7:0] g;
                                g = (cmd_reg.amount < 8'(freec)) ? cmd_reg.amount
                                                                 : 8'(freec);
                                gr_reg   <= 7'(g);
                                held_reg <= held_reg + CNT_W'(g);
                                oc_reg   <= (g != 8'd0) ? OUT_DONE : OUT_REFUSED;
                            end
                            OP_RELEASE:
                            begin
                                held_reg <= (8'(held_reg) < cmd_reg.amount) ? '0
                                          : CNT_W'(8'(held_reg) - cmd_reg.amount);
                                oc_reg   <= OUT_DONE;
                            end
                            default: ;
                        endcase
                    end
                    if (cmd_reg.op == OP_CLEAR)
                    begin
                        filled_reg <= '0;
                        peak_reg   <= '0;
                        held_reg   <= '0;
                        rdy_reg    <= 1'b1;
                        oc_reg     <= OUT_DONE;
                    end
                end
                ST_CHECK:
                begin
                    if (is_put)
                    begin
                        if (rd_span_reg == cmd_reg.span)
                        begin
                            oc_reg <= (cmd_reg.op == OP_PUT_RES) ? OUT_DUP
                                                                 : OUT_REFUSED;
                        end
                        i_reg <= i_reg + 1'b1;
                    end
                    else
                    begin
                        i_reg <= i_reg - 1'b1;
                        if (rd_cls_reg == cmd_reg.cls[CLS_W-1:0])
                        begin
                            hit_reg <= 1'b1;
                        end
                    end
                end
                ST_WRITE:
                begin
                    oc_reg <= OUT_DONE;
                    if (is_put)
                    begin
                        filled_reg <= filled_reg + 1'b1;
                        if (cmd_reg.op == OP_PUT_RES)
                        begin
                            held_reg <= held_reg - 1'b1;
                        end
                        if (filled_reg + 1'b1 > peak_reg)
                        begin
                            peak_reg <= filled_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        filled_reg <= filled_reg - 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    // output register, loaded on leaving ST_OUT
    logic [1:0]  o_oc_reg;
    logic [6:0]  o_gr_reg, o_fc_reg, o_pk_reg, o_fr_reg;
    logic [47:0] o_ts_reg;
    logic [4:0]  o_tc_reg;

    always_ff @(posedge clk)
    begin
        if (st_reg == ST_OUT && (!ov_reg || !out_stall))
        begin
            o_oc_reg <= oc_reg;
            o_gr_reg <= gr_reg;
            o_ts_reg <= (hit_reg && is_take) ? tspan_reg : '0;
            o_tc_reg <= (hit_reg && is_take) ? 5'(tcls_reg) : '0;
            o_fc_reg <= rdy_reg ? 7'(filled_reg) : '0;
            o_pk_reg <= rdy_reg ? 7'(peak_reg) : '0;
            o_fr_reg <= rdy_reg ? 7'(freec) : '0;
        end
    end

    assign out_valid   = ov_reg;
    assign outcome     = o_oc_reg;
    assign granted     = o_gr_reg;
    assign taken_span  = o_ts_reg;
    assign taken_class = o_tc_reg;
    assign entry_count = o_fc_reg;
    assign peak_count  = o_pk_reg;
    assign free_slots  = o_fr_reg;
endmodule

[rtl/span_depot_reserve_put_take.sv]
// Top level of the span depot: config registers, front end, back end.
// Depends on sdp_pkg, sdp_front, sdp_back.
//
// Usage:
//   Input channel in_valid/in_stall carries op, span_address, size_class,
//   amount, span_discarded; a beat moves when valid is high and stall low.
//   Output channel out_valid/out_stall returns one result beat per input.
//   Config channel cfg_valid/cfg_ready writes arena_base (index 0) and
//   arena_bytes (index 1); cfg_ready is always high.
//   Reserve, release, clear, unused ops and puts refused before the scan go
//   straight from ST_READ to ST_OUT; a put checks the held entries for a
//   duplicate one at a time, and a take searches down one entry at a time
//   and swap-removes the hit through ST_MOVE and ST_WRITE.
//   The back end serves one item at a time and pops no new command until
//   its result is in the output register; a two-entry queue lets the front
//   keep accepting while it works. A stalled output holds its beat and the back end waits on it.
//   After reset every op but clear is refused until the first clear.
module span_depot_reserve_put_take
    import sdp_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_stall,
    input  logic [2:0]    op,
    input  logic [47:0]   span_address,
    input  logic [7:0]    size_class,
    input  logic [7:0]    amount,
    input  logic          span_discarded,
    output logic          out_valid,
    input  logic          out_stall,
    output logic [1:0]    outcome,
    output logic [6:0]    granted,
    output logic [47:0]   taken_span,
    output logic [4:0]    taken_class,
    output logic [6:0]    entry_count,
    output logic [6:0]    peak_count,
    output logic [6:0]    free_slots,
    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  logic          cfg_index,
    input  logic [47:0]   cfg_data
);
    logic [47:0] base_reg, bytes_reg;
    logic        q_valid, q_pop;
    cmd_t        q_cmd;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg  <= '0;
            bytes_reg <= '0;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == 1'b0)
            begin
                base_reg <= cfg_data;
            end
            else
            begin
                bytes_reg <= cfg_data;
            end
        end
    end

    sdp_front u_front (
        .clk, .rst_n, .in_valid, .in_stall, .op, .span_address, .size_class,
        .amount, .span_discarded,
        .arena_base(base_reg), .arena_bytes(bytes_reg),
        .q_valid, .q_cmd, .q_pop
    );

    sdp_back u_back (
        .clk, .rst_n, .q_valid, .q_cmd, .q_pop, .out_valid, .out_stall,
        .outcome, .granted, .taken_span, .taken_class, .entry_count,
        .peak_count, .free_slots
    );
endmodule
